>>> rtl/core/text_tokenizer_stopword_filter_macros.svh
// assertion macros for the tokenizer
`ifndef TEXT_TOKENIZER_STOPWORD_FILTER_MACROS_SVH
`define TEXT_TOKENIZER_STOPWORD_FILTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// antecedent implies consequent in the next cycle
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

>>> rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// types and constant tables shared by the tokenizer modules
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int NUM_STOP = 35;
    localparam int NUM_PAT  = 5;
    localparam int WIN_LEN  = 7;

    // stopwords, left aligned, first character in the top byte
    localparam logic [31:0] STOP_WORD [NUM_STOP] = '{
        {"a", 24'h0}, {"an", 16'h0}, {"and", 8'h0}, {"are", 8'h0}, {"as", 16'h0},
        {"at", 16'h0}, {"be", 16'h0}, {"by", 16'h0}, {"for", 8'h0}, "from",
        {"has", 8'h0}, "have", {"he", 16'h0}, {"in", 16'h0}, {"is", 16'h0},
        {"it", 16'h0}, {"its", 8'h0}, {"of", 16'h0}, {"on", 16'h0}, {"or", 16'h0},
        "that", {"the", 8'h0}, "this", {"to", 16'h0}, {"was", 8'h0}, "were",
        "will", "with", {"you", 8'h0}, "your", {"i", 24'h0}, {"we", 16'h0},
        "they", {"but", 8'h0}, {"not", 8'h0}
    };

    localparam logic [2:0] STOP_LEN [NUM_STOP] = '{
        3'd1, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd1, 3'd2, 3'd4, 3'd3, 3'd3
    };

    localparam logic [55:0] PAT_TEXT [NUM_PAT] = '{
        {"c++", 32'h0}, {"c#", 40'h0}, {"f#", 40'h0}, {".net", 24'h0}, "node.js"
    };
    localparam logic [2:0] PAT_LEN [NUM_PAT] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd7};

    localparam logic [47:0] REP_TEXT [NUM_PAT] = '{
        {"cpp", 24'h0}, "csharp", "fsharp", "dotnet", "nodejs"
    };
    localparam logic [2:0] REP_LEN [NUM_PAT] = '{3'd3, 3'd6, 3'd6, 3'd6, 3'd6};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REP,
        S_FIN,
        S_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_rep;
        logic feed_rep;
        logic feed_win;
        logic clear_tok;
        logic emit_start;
        logic emit_next;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic eot;
        logic hit;
        logic prefix;
        logic cur_alnum;
        logic tok_nonempty;
        logic keep;
        logic rep_last;
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/core/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// sequencer: scan of the lookahead window, rewrite feed, token emission
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire tts_pkg::t_dp_status i_st,
    output tts_pkg::t_dp_cmd        o_cmd
);

    tts_pkg::t_state r_state;
    tts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            tts_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = tts_pkg::S_SCAN;
                end
            end
            tts_pkg::S_SCAN: begin
                priority if (i_st.cnt_zero) begin
                    if (i_st.eot && i_st.tok_nonempty) begin
                        n_state = tts_pkg::S_FIN;
                    end else begin
                        n_state = tts_pkg::S_IDLE;
                    end
                end else if (i_st.hit) begin
                    o_cmd.start_rep = 1'b1;
                    n_state         = tts_pkg::S_REP;
                end else if (i_st.prefix && !i_st.eot) begin
                    n_state = tts_pkg::S_IDLE;
                end else begin
                    o_cmd.feed_win = 1'b1;
                    if (!i_st.cur_alnum && i_st.tok_nonempty) begin
                        n_state = tts_pkg::S_FIN;
                    end
                end
            end
            tts_pkg::S_REP: begin
                o_cmd.feed_rep = 1'b1;
                if (i_st.rep_last) begin
                    n_state = tts_pkg::S_SCAN;
                end
            end
            tts_pkg::S_FIN: begin
                if (i_st.keep) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = tts_pkg::S_RD;
                end else begin
                    o_cmd.clear_tok = 1'b1;
                    n_state         = tts_pkg::S_SCAN;
                end
            end
            tts_pkg::S_RD: begin
                n_state = tts_pkg::S_OUT;
            end
            tts_pkg::S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_st.emit_last) begin
                        o_cmd.clear_tok = 1'b1;
                        n_state         = tts_pkg::S_SCAN;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = tts_pkg::S_RD;
                    end
                end
            end
            default: begin
                n_state = tts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tts_dp.sv
// ----------------------------------------------------------------------------
// tts_dp
// datapath: lookahead window, pattern match, token buffer, stopword mask,
// output register
// ----------------------------------------------------------------------------
`default_nettype none

module tts_dp #(
    parameter int MAX_TOKEN_CHARS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [5:0]           i_cfg_data,
    input  wire logic [7:0]           i_char_code,
    input  wire logic                 i_end_of_text,
    input  wire logic                 i_stall,
    input  wire tts_pkg::t_dp_cmd     i_cmd,
    output tts_pkg::t_dp_status       o_st,
    output logic                      o_valid,
    output logic [7:0]                o_token_char,
    output logic                      o_token_last,
    output logic                      o_token_truncated
);

`include "text_tokenizer_stopword_filter_macros.svh"

    localparam int AW  = $clog2(MAX_TOKEN_CHARS);
    localparam int TLW = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int EW  = (TLW + 1 > 7) ? TLW + 1 : 7;
    localparam int WL  = tts_pkg::WIN_LEN;
    localparam int NS  = tts_pkg::NUM_STOP;
    localparam int NP  = tts_pkg::NUM_PAT;

    logic [7:0]     r_win [WL];
    logic [7:0]     n_win [WL];
    logic [2:0]     r_cnt;
    logic [2:0]     n_cnt;
    logic           r_eot;
    logic [5:0]     r_min;
    logic [TLW-1:0] r_tlen;
    logic [TLW-1:0] n_tlen;
    logic           r_ovf;
    logic           n_ovf;
    logic [NS-1:0]  r_mask;
    logic [NS-1:0]  n_mask;
    logic [2:0]     r_rep_sel;
    logic [2:0]     r_rep_idx;
    logic [AW-1:0]  r_eidx;
    logic           r_o_valid;
    logic [7:0]     r_o_char;
    logic           r_o_last;
    logic           r_o_trunc;

    logic [7:0]     in_char;
    logic [NP-1:0]  full;
    logic [NP-1:0]  pre;
    logic [2:0]     hit_sel;
    logic [2:0]     shamt;
    logic [3:0]     src;
    logic [7:0]     feed_char;
    logic           win_alnum;
    logic           do_feed;
    logic           ram_we;
    logic           room;
    logic [7:0]     rdata;
    logic           stop;
    logic [EW-1:0]  eff;
    logic [1:0]     pos;

    assign in_char = (i_char_code >= "A" && i_char_code <= "Z") ?
                     (i_char_code + 8'd32) : i_char_code;

    assign win_alnum = (r_win[0] >= "a" && r_win[0] <= "z") ||
                       (r_win[0] >= "0" && r_win[0] <= "9");

    // pattern match at the head of the window
    always_comb begin
        hit_sel = '0;
        for (int p = 0; p < NP; p++) begin
            full[p] = (r_cnt >= tts_pkg::PAT_LEN[p]);
            pre[p]  = (r_cnt < tts_pkg::PAT_LEN[p]);
            for (int j = 0; j < WL; j++) begin
                if (3'(j) < tts_pkg::PAT_LEN[p] &&
                    r_win[j] != tts_pkg::PAT_TEXT[p][8*(6-j) +: 8]) begin
                    full[p] = 1'b0;
                end
                if (3'(j) < r_cnt &&
                    r_win[j] != tts_pkg::PAT_TEXT[p][8*(6-j) +: 8]) begin
                    pre[p] = 1'b0;
                end
            end
        end
        for (int p = NP - 1; p >= 0; p--) begin
            if (full[p]) begin
                hit_sel = 3'(p);
            end
        end
    end

    assign room      = r_tlen < TLW'(MAX_TOKEN_CHARS);
    assign feed_char = i_cmd.feed_rep ?
                       tts_pkg::REP_TEXT[r_rep_sel][8*(5-r_rep_idx) +: 8] : r_win[0];
    assign do_feed   = i_cmd.feed_rep || (i_cmd.feed_win && win_alnum);
    assign ram_we    = do_feed && room;
    assign pos       = r_tlen[1:0];

    always_comb begin
        stop = 1'b0;
        for (int k = 0; k < NS; k++) begin
            if (r_mask[k] && r_tlen == TLW'(tts_pkg::STOP_LEN[k])) begin
                stop = 1'b1;
            end
        end
        stop = stop && !r_ovf;
    end

    assign eff = r_ovf ? EW'(MAX_TOKEN_CHARS + 1) : EW'(r_tlen);

    // next state of window and token
    always_comb begin
        n_win  = r_win;
        n_cnt  = r_cnt;
        n_tlen = r_tlen;
        n_ovf  = r_ovf;
        n_mask = r_mask;
        shamt  = '0;
        src    = '0;
        if (i_cmd.accept) begin
            n_win[r_cnt] = in_char;
            n_cnt        = r_cnt + 3'd1;
        end
        if (i_cmd.start_rep || i_cmd.feed_win) begin
            shamt = i_cmd.start_rep ? tts_pkg::PAT_LEN[hit_sel] : 3'd1;
            for (int i = 0; i < WL; i++) begin
                src = 4'(i) + {1'b0, shamt};
                if (src < 4'(WL)) begin
                    n_win[i] = r_win[src[2:0]];
                end
            end
            n_cnt = r_cnt - shamt;
        end
        if (do_feed) begin
            if (room) begin
                n_tlen = r_tlen + TLW'(1);
                for (int k = 0; k < NS; k++) begin
                    n_mask[k] = r_mask[k] && (r_tlen < TLW'(4)) &&
                                (TLW'(tts_pkg::STOP_LEN[k]) > r_tlen) &&
                                (tts_pkg::STOP_WORD[k][8*(3-pos) +: 8] == feed_char);
                end
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.clear_tok) begin
            n_tlen = '0;
            n_ovf  = 1'b0;
            n_mask = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (i_cmd.accept) begin
            r_eot <= i_end_of_text;
        end
        if (i_cmd.start_rep) begin
            r_rep_sel <= hit_sel;
        end
        if (i_cmd.out_load) begin
            r_o_char  <= rdata;
            r_o_last  <= o_st.emit_last;
            r_o_trunc <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_min     <= 6'd2;
            r_tlen    <= '0;
            r_ovf     <= 1'b0;
            r_mask    <= '1;
            r_rep_idx <= '0;
            r_eidx    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_tlen <= n_tlen;
            r_ovf  <= n_ovf;
            r_mask <= n_mask;
            if (i_cfg_we) begin
                r_min <= i_cfg_data;
            end
            if (i_cmd.start_rep) begin
                r_rep_idx <= '0;
            end else if (i_cmd.feed_rep) begin
                r_rep_idx <= r_rep_idx + 3'd1;
            end
            if (i_cmd.emit_start) begin
                r_eidx <= '0;
            end else if (i_cmd.emit_next) begin
                r_eidx <= r_eidx + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    tts_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TOKEN_CHARS)
    ) u_tok_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tlen[AW-1:0]),
        .i_wdata (feed_char),
        .i_raddr (r_eidx),
        .o_rdata (rdata)
    );

    always_comb begin
        o_st              = '0;
        o_st.cnt_zero     = (r_cnt == 3'd0);
        o_st.eot          = r_eot;
        o_st.hit          = |full;
        o_st.prefix       = |pre;
        o_st.cur_alnum    = win_alnum;
        o_st.tok_nonempty = (r_tlen != '0);
        o_st.keep         = (eff >= EW'(r_min)) && !stop && (r_tlen != '0);
        o_st.rep_last     = (r_rep_idx == tts_pkg::REP_LEN[r_rep_sel] - 3'd1);
        o_st.emit_last    = (TLW'(r_eidx) + TLW'(1) == r_tlen);
        o_st.out_free     = !r_o_valid || !i_stall;
    end

    assign o_valid           = r_o_valid;
    assign o_token_char      = r_o_char;
    assign o_token_last      = r_o_last;
    assign o_token_truncated = r_o_trunc;

    `TTS_ASSERT_IMP(a_accept_room, i_clk, i_rst_n, i_cmd.accept, r_cnt <= 3'd6)
    `TTS_ASSERT_IMP(a_tlen_bound, i_clk, i_rst_n, 1'b1, r_tlen <= TLW'(MAX_TOKEN_CHARS))
    `TTS_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, r_ovf, r_tlen == TLW'(MAX_TOKEN_CHARS))
    `TTS_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.out_load, !r_o_valid || !i_stall)

endmodule

`default_nettype wire

>>> rtl/core/text_tokenizer_stopword_filter.sv
// steps: an accepted byte is taken in the idle state, then each window byte
// is scanned, each rewrite character fed, a finished token judged, and each
// emitted character read from the token buffer ram, then loaded into the
// output register once it is free, until the window is found empty. a new byte
// is taken only back in idle; the input stalls while a token is emitted.
// reset: synchronous active low, clears control state.
// ----------------------------------------------------------------------------
// text_tokenizer_stopword_filter
// lower-case tokenizer with pattern rewrite and stopword removal
// ----------------------------------------------------------------------------
`default_nettype none

module text_tokenizer_stopword_filter #(
    parameter int MAX_TOKEN_CHARS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_token_char,
    output logic            o_token_last,
    output logic            o_token_truncated
);

    tts_pkg::t_dp_cmd    cmd;
    tts_pkg::t_dp_status st;

    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    tts_dp #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_char_code       (i_char_code),
        .i_end_of_text     (i_end_of_text),
        .i_stall           (i_stall),
        .i_cmd             (cmd),
        .o_st              (st),
        .o_valid           (o_valid),
        .o_token_char      (o_token_char),
        .o_token_last      (o_token_last),
        .o_token_truncated (o_token_truncated)
    );

endmodule

`default_nettype wire
